/* src/lcmf_pkg.sv */
// Shared constants and control types for the LCM factoring unit.
// No dependencies; imported by every module of the block.
package lcmf_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int IN_W       = 16;
	localparam int PROD_W     = 32;
	localparam int EXT_W      = (DATA_WIDTH > IN_W) ? DATA_WIDTH : IN_W;
	localparam int SQ_W       = 2 * DATA_WIDTH;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic square;
		logic div_start;
		logic div_step;
		logic apply;
		logic fin_a;
		logic fin_b;
		logic result_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_zero;
		logic both_one;
		logic sq_gt_big;
	} status_t;

endpackage

/* src/lcm_by_prime_factoring_unit.sv */
// LCM by simultaneous trial-division factoring, W = DATA_WIDTH (16).
// Each trial squares the divisor, compares it with the larger value, divides both values
// by it bit-serially and then divides out or increments; zero operands skip to the result.
// One word in flight: the next word is taken once the result word is loaded into the
// output register, and that load waits while the previous result word stalls.
// Asynchronous active-low reset returns the controller to idle with no output pending.
module lcm_by_prime_factoring_unit import lcmf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [IN_W-1:0]   first_value,
	input  logic [IN_W-1:0]   second_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PROD_W-1:0] multiple,
	output logic              bad_operand
);

	cmd_t    cmd;
	status_t status;

	lcmf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
	);

	lcmf_datapath u_dp (
		.clk(clk), .cmd(cmd), .first_value(first_value), .second_value(second_value),
		.status(status), .multiple(multiple), .bad_operand(bad_operand)
	);

endmodule

/* src/lcmf_div.sv */
// Restoring divider, one quotient bit per step.
// Depends on lcmf_pkg for the operand width.
module lcmf_div import lcmf_pkg::*; (
	input  logic                  clk,
	input  logic                  start,
	input  logic                  step,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);

	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  fits;

	assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (step) begin
			// remainder stays below divisor, so the top bit drops safely
			rem_q <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
			quo_q <= {quo_q[DATA_WIDTH-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* src/lcmf_datapath.sv */
// Datapath: working values, trial divisor, running product, two dividers,
// shared product multiplier and the result register. Depends on lcmf_pkg, lcmf_div.
module lcmf_datapath import lcmf_pkg::*; (
	input  logic             clk,
	input  cmd_t             cmd,
	input  logic [IN_W-1:0]  first_value,
	input  logic [IN_W-1:0]  second_value,
	output status_t          status,
	output logic [PROD_W-1:0] multiple,
	output logic             bad_operand
);

	logic [DATA_WIDTH-1:0] a_q, b_q, d_q;
	logic [SQ_W-1:0]       sq_q;
	logic [PROD_W-1:0]     product_q;
	logic                  bad_q;
	logic [PROD_W-1:0]     multiple_q;
	logic                  bad_operand_q;

	logic [EXT_W-1:0]      a_ext, b_ext;
	logic [DATA_WIDTH-1:0] a_in, b_in;
	logic [DATA_WIDTH-1:0] big;
	logic [DATA_WIDTH-1:0] quo_a, rem_a, quo_b, rem_b;
	logic [DATA_WIDTH-1:0] mul_op;
	logic [PROD_W-1:0]     mul_full;
	logic                  div_a, div_b, a_gt1, b_fin;

	assign a_ext = EXT_W'(first_value);
	assign b_ext = EXT_W'(second_value);
	assign a_in  = a_ext[DATA_WIDTH-1:0];
	assign b_in  = b_ext[DATA_WIDTH-1:0];

	assign big    = (a_q > b_q) ? a_q : b_q;
	assign div_a  = rem_a == '0;
	assign div_b  = rem_b == '0;
	assign a_gt1  = a_q > DATA_WIDTH'(1);
	assign b_fin  = (b_q > DATA_WIDTH'(1)) && (b_q != a_q);

	assign status.in_zero   = (a_in == '0) || (b_in == '0);
	assign status.both_one  = (a_q == DATA_WIDTH'(1)) && (b_q == DATA_WIDTH'(1));
	assign status.sq_gt_big = sq_q > SQ_W'(big);

	lcmf_div u_div_a (
		.clk(clk), .start(cmd.div_start), .step(cmd.div_step),
		.dividend(a_q), .divisor(d_q), .quotient(quo_a), .remainder(rem_a)
	);

	lcmf_div u_div_b (
		.clk(clk), .start(cmd.div_start), .step(cmd.div_step),
		.dividend(b_q), .divisor(d_q), .quotient(quo_b), .remainder(rem_b)
	);

	always_comb begin
		mul_op = d_q;
		if (cmd.fin_a)
			mul_op = a_q;
		else if (cmd.fin_b)
			mul_op = b_q;
	end

	// keep the low product bits only
	assign mul_full = product_q * PROD_W'(mul_op);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q       <= a_in;
			b_q       <= b_in;
			d_q       <= DATA_WIDTH'(2);
			product_q <= status.in_zero ? '0 : PROD_W'(1);
			bad_q     <= status.in_zero;
		end
		if (cmd.square)
			sq_q <= SQ_W'(d_q) * SQ_W'(d_q);
		if (cmd.apply) begin
			if (div_a)
				a_q <= quo_a;
			if (div_b)
				b_q <= quo_b;
			if (div_a || div_b)
				product_q <= mul_full;
			else
				d_q <= d_q + DATA_WIDTH'(1);
		end
		// leftover values above one are prime here
		if (cmd.fin_a && a_gt1)
			product_q <= mul_full;
		if (cmd.fin_b && b_fin)
			product_q <= mul_full;
		if (cmd.result_load) begin
			multiple_q    <= product_q;
			bad_operand_q <= bad_q;
		end
	end

	assign multiple    = multiple_q;
	assign bad_operand = bad_operand_q;

endmodule

/* src/lcmf_ctrl.sv */
// Controller: sequences load, trial steps, final products and result handoff.
// Depends on lcmf_pkg for command and status types.
module lcmf_ctrl import lcmf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_TEST, S_DIV, S_APPLY, S_FIN_A, S_FIN_B, S_DONE
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.in_zero ? S_DONE : S_SQ;
				end
			end
			S_SQ: begin
				cmd.square = 1'b1;
				state_d    = S_TEST;
			end
			S_TEST: begin
				if (status.both_one)
					state_d = S_DONE;
				else if (status.sq_gt_big)
					state_d = S_FIN_A;
				else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DATA_WIDTH - 1))
					state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_SQ;
			end
			S_FIN_A: begin
				cmd.fin_a = 1'b1;
				state_d   = S_FIN_B;
			end
			S_FIN_B: begin
				cmd.fin_b = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the word
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.result_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/lcmf_checker.sv */
// Port-level checks for the LCM factoring unit, bound to the top level.
// Depends on lcmf_pkg and lcm_by_prime_factoring_unit.
module lcmf_checker import lcmf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PROD_W-1:0] multiple,
	input logic              bad_operand
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(multiple) && $stable(bad_operand))
		else $error("result word changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_operand |-> multiple == '0)
		else $error("flagged word carries a nonzero multiple");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_operand |-> multiple != '0)
		else $error("unflagged word carries a zero multiple");

	// one word in flight: ready drops in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after accept");

endmodule

bind lcm_by_prime_factoring_unit lcmf_checker u_chk (.*);

/* bench/lcm_result_checker.sv */
// Result checker for the LCM factoring unit: watches both channels, predicts each result
// word by trial division and compares it field by field. Depends on lcmf_pkg.
module lcm_result_checker import lcmf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [IN_W-1:0]   first_value,
	input  logic [IN_W-1:0]   second_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [PROD_W-1:0] multiple,
	input  logic              bad_operand,
	output int                outstanding,
	output int                fail_count
);

	typedef struct packed {
		logic [PROD_W-1:0] multiple;
		logic              bad_operand;
	} lcm_word_t;

	lcm_word_t lcm_expected[$];
	int        mismatches = 0;

	assign fail_count = mismatches;

	function automatic lcm_word_t predict_lcm(input logic [IN_W-1:0] a_in,
						  input logic [IN_W-1:0] b_in);
		longint unsigned mask;
		longint unsigned a;
		longint unsigned b;
		longint unsigned d;
		longint unsigned big;
		longint unsigned prod;
		bit              done;
		bit              da;
		bit              db;
		lcm_word_t       w;
		mask = (64'd1 << DATA_WIDTH) - 64'd1;
		a    = a_in;
		b    = b_in;
		a    = a & mask;
		b    = b & mask;
		if (a == 0 || b == 0) begin
			w.multiple    = '0;
			w.bad_operand = 1'b1;
			return w;
		end
		prod = 1;
		d    = 2;
		done = 1'b0;
		while (!done && (a != 1 || b != 1)) begin
			big = (a > b) ? a : b;
			// whatever is left above 1 is prime once d*d passes both values
			if (d * d > big) begin
				if (a > 1)
					prod = prod * a;
				if (b > 1 && b != a)
					prod = prod * b;
				done = 1'b1;
			end else begin
				da = (a % d) == 0;
				db = (b % d) == 0;
				if (da || db) begin
					if (da)
						a = a / d;
					if (db)
						b = b / d;
					prod = prod * d;
				end else begin
					d = d + 1;
				end
			end
		end
		w.multiple    = prod[PROD_W-1:0];
		w.bad_operand = 1'b0;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcm_word_t want;
		if (!arst_n) begin
			lcm_expected.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				lcm_expected.push_back(predict_lcm(first_value, second_value));
			if (out_valid && out_ready) begin
				if (lcm_expected.size() == 0) begin
					$error("result word with nothing expected: multiple=%0d bad_operand=%0b",
						multiple, bad_operand);
					mismatches++;
				end else begin
					want = lcm_expected.pop_front();
					if (multiple !== want.multiple) begin
						$error("multiple: expected %0d, got %0d", want.multiple, multiple);
						mismatches++;
					end
					if (bad_operand !== want.bad_operand) begin
						$error("bad_operand: expected %0b, got %0b",
							want.bad_operand, bad_operand);
						mismatches++;
					end
				end
			end
			outstanding <= lcm_expected.size();
		end
	end

endmodule

/* bench/lcm_by_prime_factoring_unit_tb.sv */
// Testbench top for the LCM factoring unit: clock, reset, operand and ready stimulus,
// watchdog and verdict. Depends on lcmf_pkg, the unit and lcm_result_checker.
module lcm_by_prime_factoring_unit_tb import lcmf_pkg::*; ();

	localparam int STALL_LIMIT = 40000;
	localparam int LONG_HOLD   = 600;
	localparam int HOLD_AFTER  = 25;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [IN_W-1:0]   first_value;
	logic [IN_W-1:0]   second_value;
	logic              out_valid;
	logic              out_ready;
	logic [PROD_W-1:0] multiple;
	logic              bad_operand;

	int outstanding;
	int fail_count;
	int stall_cycles = 0;
	bit no_idle      = 1'b0;

	lcm_by_prime_factoring_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_value  (first_value),
		.second_value (second_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.multiple     (multiple),
		.bad_operand  (bad_operand)
	);

	lcm_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_value  (first_value),
		.second_value (second_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.multiple     (multiple),
		.bad_operand  (bad_operand),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	task automatic send_word(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
		int gap;
		first_value  <= a;
		second_value <= b;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_word();
		int r;
		int k;
		logic [IN_W-1:0] a;
		logic [IN_W-1:0] b;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			a = IN_W'($urandom);
			b = IN_W'($urandom);
		end else if (r < 65) begin
			a = IN_W'($urandom_range(1, 255));
			b = IN_W'($urandom_range(1, 255));
		end else if (r < 85) begin
			// share a factor between both operands
			k = $urandom_range(2, 250);
			a = IN_W'(k * $urandom_range(1, 65535 / k));
			b = IN_W'(k * $urandom_range(1, 65535 / k));
		end else if (r < 95) begin
			a = IN_W'(1 << $urandom_range(0, IN_W - 1));
			b = IN_W'($urandom_range(1, 65535));
		end else begin
			a = IN_W'($urandom);
			b = IN_W'($urandom);
			if ($urandom_range(0, 1))
				a = '0;
			else
				b = '0;
		end
		send_word(a, b);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin : receiver
		int gap;
		int taken;
		bit held;
		gap   = 0;
		taken = 0;
		held  = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				taken++;
				// hold off once for a long stretch so the input side backs up
				if (taken == HOLD_AFTER && !held) begin
					held = 1'b1;
					gap  = LONG_HOLD;
				end else begin
					gap = idle_length();
				end
			end else if (gap == 0 && $urandom_range(0, 7) == 0) begin
				gap = idle_length();
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		in_valid     <= 1'b0;
		first_value  <= '0;
		second_value <= '0;
		arst_n       <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero operands, ones, extremes, primes and prime powers
		send_word(16'd0, 16'd0);
		send_word(16'd0, 16'd5);
		send_word(16'd7, 16'd0);
		send_word(16'd1, 16'd1);
		send_word(16'd1, 16'd65535);
		send_word(16'd65535, 16'd1);
		send_word(16'd65535, 16'd65535);
		send_word(16'd65535, 16'd65534);
		send_word(16'd65521, 16'd65521);
		send_word(16'd65521, 16'd65519);
		send_word(16'd1, 16'd65521);
		send_word(16'd63001, 16'd63001);
		send_word(16'd63001, 16'd251);
		send_word(16'd2, 16'd2);
		send_word(16'd2, 16'd3);
		send_word(16'd32768, 16'd32768);
		send_word(16'd32768, 16'd3);
		send_word(16'd12, 16'd18);
		send_word(16'd4, 16'd6);
		send_word(16'hAAAA, 16'h5555);
		send_word(16'h5555, 16'hAAAA);

		for (n = 0; n < 100; n++) begin
			if (n == 40)
				no_idle = 1'b1;
			if (n == 60)
				no_idle = 1'b0;
			// let the unit run dry before going on
			if (n == 70)
				drain_results();
			send_random_word();
		end

		drain_results();
		repeat (25) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
src/lcmf_pkg.sv
src/lcmf_div.sv
src/lcmf_datapath.sv
src/lcmf_ctrl.sv
src/lcm_by_prime_factoring_unit.sv
src/lcmf_checker.sv
bench/lcm_result_checker.sv
bench/lcm_by_prime_factoring_unit_tb.sv
